FILE: rtl/core/rfd_pkg.sv
// shared types and constants for the response frame deframer
`default_nettype none

package rfd_pkg;

  // framing and command codes
  localparam logic [7:0] START_BYTE = 8'hCA;
  localparam logic [7:0] CMD_COUNT  = 8'h65;
  localparam logic [7:0] CMD_INFO   = 8'h69;
  localparam logic [7:0] CMD_ACK    = 8'h60;
  localparam logic [7:0] CMD_METER  = 8'h68;

  // fixed capture offsets inside a frame
  localparam logic [16:0] OFF_LEN_LO  = 17'd1;
  localparam logic [16:0] OFF_COMMAND = 17'd4;
  localparam logic [16:0] OFF_ID_HI   = 17'd6;
  localparam logic [16:0] OFF_ID_LO   = 17'd7;
  localparam logic [16:0] OFF_PAR_HI  = 17'd8;
  localparam logic [16:0] OFF_PAR_LO  = 17'd9;
  localparam logic [16:0] OFF_STATUS  = 17'd26;

  // frame classification reported on the last word
  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_COUNT = 3'd1,
    KIND_INFO  = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_METER = 3'd4
  } kind_e;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HDR  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  // one decoded output word
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [16:0] byte_offset;
    logic [15:0] payload_len;
    logic [7:0]  command;
    logic        is_last;
    kind_e       frame_kind;
    logic [15:0] node_count;
    logic [15:0] node_id;
    logic [15:0] uplink_id;
    logic [7:0]  link_status;
  } result_t;

  // handshake between input register and parser
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_word_t;

endpackage

`default_nettype wire

FILE: rtl/core/response_frame_deframer_top.sv
// top level of the response frame deframer
//
// Input stream: one received serial byte per word on s_axis. Bytes outside a
// frame are dropped until a 0xCA start byte; every frame byte (start byte,
// length, payload, checksum) leaves on m_axis with its offset, the length,
// the command and the captured node fields. tlast marks the checksum byte,
// tuser carries the frame kind on that word and is zero elsewhere.
// Path: a byte leaves m_axis through the input register, then the output
// register, with the decode done between the two.
// Throughput: one word per cycle, sustained while m_axis_tready is high; the
// parser state advances once per byte, so bytes may follow back to back.
// Reset: the parser returns to hunting for a start byte, the stored node count
// and all captures clear, both registers are emptied.
// Stall: while m_axis is held, the output word stays put; the input register
// still takes one more byte, and dropped bytes keep draining since they make
// no output word. Back-pressure reaches s_axis_tready after that.
`default_nettype none

module response_frame_deframer_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input stream, tdata: rx_byte[7:0]
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,
  // output stream, tdata: frame_byte[7:0], byte_offset[24:8],
  // payload_len[40:25], command[48:41], node_count[64:49], node_id[80:65],
  // uplink_id[96:81], link_status[104:97], zero fill[111:105]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [111:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  // tuser: frame_kind[2:0]
  output logic [2:0]        m_axis_tuser
);

  rfd_pkg::in_word_t in_word;
  rfd_pkg::result_t  res;
  rfd_pkg::result_t  res_q;
  logic              res_valid;
  logic              step;
  logic              out_valid_q;
  logic              out_valid_d;

  // the held byte moves on unless it makes a word and the output is blocked
  assign step = in_word.valid && (!res_valid || !out_valid_q || m_axis_tready);

  rfd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .take_i    (step),
    .word_o    (in_word)
  );

  rfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (in_word),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.is_last;
  assign m_axis_tuser  = res_q.frame_kind;
  assign m_axis_tdata  = {7'd0, res_q.link_status, res_q.uplink_id, res_q.node_id,
                          res_q.node_count, res_q.command, res_q.payload_len,
                          res_q.byte_offset, res_q.frame_byte};

  // kind is only reported on the closing word
  a_kind_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == rfd_pkg::KIND_OTHER)
    else $error("frame kind set on a word that is not last");

  // node info fields only appear on node info frames
  a_info_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != rfd_pkg::KIND_INFO
      |-> res_q.node_id == '0 && res_q.uplink_id == '0 && res_q.link_status == '0)
    else $error("node info fields set outside a node info frame");

  // offset zero is always the start byte
  a_start_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.byte_offset == '0 |-> res_q.frame_byte == rfd_pkg::START_BYTE)
    else $error("offset zero word is not a start byte");

  // input side only stalls with a byte held
  a_ready_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_word.valid && out_valid_q && !m_axis_tready)
    else $error("input stalled without a blocked byte");

endmodule

`default_nettype wire

FILE: rtl/core/rfd_in_reg.sv
// input register stage of the response frame deframer
`default_nettype none

module rfd_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire logic [7:0]       s_byte_i,
  input  wire logic             take_i,
  output rfd_pkg::in_word_t     word_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  // free when empty or when the held word moves on this cycle
  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= s_byte_i;
    end
  end

  assign word_o.valid   = valid_q;
  assign word_o.rx_byte = byte_q;

endmodule

`default_nettype wire

FILE: rtl/core/rfd_parser.sv
// frame state, field captures and word decode of the response frame deframer
`default_nettype none

module rfd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rfd_pkg::in_word_t word_i,
  input  wire logic              step_i,
  output logic                   res_valid_o,
  output rfd_pkg::result_t       res_o
);

  rfd_pkg::phase_e phase_q, phase_d;
  logic [16:0] offset_q, offset_d;
  logic [15:0] len_q, len_d;
  logic [16:0] body_q, body_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] count_q, count_d;
  logic [15:0] w67_q, w67_d;
  logic [15:0] w89_q, w89_d;
  logic [7:0]  status_q, status_d;

  logic [7:0]  b;
  logic [16:0] len_plus1;

  assign b         = word_i.rx_byte;
  assign len_plus1 = {1'b0, len_q} + 17'd1;

  // next state and decoded word
  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    len_d    = len_q;
    body_d   = body_q;
    cmd_d    = cmd_q;
    count_d  = count_q;
    w67_d    = w67_q;
    w89_d    = w89_q;
    status_d = status_q;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.frame_byte = b;
    res_o.frame_kind = rfd_pkg::KIND_OTHER;

    unique case (phase_q)
      rfd_pkg::PH_IDLE: begin
        if (b == rfd_pkg::START_BYTE) begin
          res_valid_o = 1'b1;
          len_d    = '0;
          body_d   = '0;
          cmd_d    = '0;
          w67_d    = '0;
          w89_d    = '0;
          status_d = '0;
          offset_d = 17'd1;
          phase_d  = rfd_pkg::PH_HDR;
        end
      end
      rfd_pkg::PH_HDR: begin
        res_valid_o = 1'b1;
        if (offset_q == rfd_pkg::OFF_LEN_LO) begin
          len_d = {8'd0, b};
        end else begin
          len_d   = {b, len_q[7:0]};
          phase_d = rfd_pkg::PH_BODY;
        end
        offset_d = offset_q + 17'd1;
      end
      rfd_pkg::PH_BODY: begin
        res_valid_o = 1'b1;
        // fixed-offset captures
        if (offset_q == rfd_pkg::OFF_COMMAND) cmd_d = b;
        if (offset_q == rfd_pkg::OFF_ID_HI)   w67_d = {b, w67_q[7:0]};
        if (offset_q == rfd_pkg::OFF_ID_LO)   w67_d = {w67_q[15:8], b};
        if (offset_q == rfd_pkg::OFF_PAR_HI)  w89_d = {b, w89_q[7:0]};
        if (offset_q == rfd_pkg::OFF_PAR_LO)  w89_d = {w89_q[15:8], b};
        if (offset_q == rfd_pkg::OFF_STATUS)  status_d = b;
        body_d   = body_q + 17'd1;
        offset_d = offset_q + 17'd1;
        // checksum byte closes the frame
        if (body_d == len_plus1) begin
          res_o.is_last = 1'b1;
          phase_d = rfd_pkg::PH_IDLE;
          priority if (cmd_d == rfd_pkg::CMD_COUNT) begin
            res_o.frame_kind = rfd_pkg::KIND_COUNT;
            count_d = {w89_d[7:0], w89_d[15:8]};
          end else if (cmd_d == rfd_pkg::CMD_INFO) begin
            res_o.frame_kind  = rfd_pkg::KIND_INFO;
            res_o.node_id     = w67_d;
            res_o.uplink_id   = w89_d;
            res_o.link_status = status_d;
          end else if (cmd_d == rfd_pkg::CMD_ACK) begin
            res_o.frame_kind = rfd_pkg::KIND_ACK;
          end else if (cmd_d == rfd_pkg::CMD_METER) begin
            res_o.frame_kind = rfd_pkg::KIND_METER;
          end else begin
            res_o.frame_kind = rfd_pkg::KIND_OTHER;
          end
        end
      end
      default: begin
        phase_d = rfd_pkg::PH_IDLE;
      end
    endcase

    // a word only comes from a held byte
    res_valid_o = res_valid_o && word_i.valid;

    res_o.byte_offset = (phase_q == rfd_pkg::PH_IDLE) ? 17'd0 : offset_q;
    res_o.payload_len = len_d;
    res_o.command     = cmd_d;
    res_o.node_count  = count_d;
  end

  // state update once per consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rfd_pkg::PH_IDLE;
      offset_q <= '0;
      len_q    <= '0;
      body_q   <= '0;
      cmd_q    <= '0;
      count_q  <= '0;
      w67_q    <= '0;
      w89_q    <= '0;
      status_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      len_q    <= len_d;
      body_q   <= body_d;
      cmd_q    <= cmd_d;
      count_q  <= count_d;
      w67_q    <= w67_d;
      w89_q    <= w89_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire
